### src/assert_macros.svh
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### src/gtg_pkg.sv
`default_nettype none
package gtg_pkg;
  localparam int CordicSteps = 16;
  localparam int AngW = 40;
  localparam logic signed [AngW-1:0] HalfPiQ16 = 40'sd102944;
  localparam logic signed [17:0] PiQ13 = 18'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;

  localparam logic [2:0] CfgTargetX = 3'd0;
  localparam logic [2:0] CfgTargetY = 3'd1;
  localparam logic [2:0] CfgGain = 3'd2;
  localparam logic [2:0] CfgArrive = 3'd3;
  localparam logic [2:0] CfgHeading = 3'd4;
  localparam logic [2:0] CfgLinear = 3'd5;
  localparam logic [2:0] CfgAngular = 3'd6;

  function automatic logic [16:0] atan_entry(input logic [4:0] i);
    logic [16:0] r;
    begin
      case (i)
        5'd0: r = 17'd51472;
        5'd1: r = 17'd30386;
        5'd2: r = 17'd16055;
        5'd3: r = 17'd8150;
        5'd4: r = 17'd4091;
        5'd5: r = 17'd2047;
        5'd6: r = 17'd1024;
        5'd7: r = 17'd512;
        5'd8: r = 17'd256;
        5'd9: r = 17'd128;
        5'd10: r = 17'd64;
        5'd11: r = 17'd32;
        5'd12: r = 17'd16;
        5'd13: r = 17'd8;
        5'd14: r = 17'd4;
        5'd15: r = 17'd2;
        5'd16: r = 17'd1;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

### src/go_to_goal_rotate_then_drive.sv
// Sequence: the accepted item's squares are formed and summed, then the square root
// runs, then two CORDIC runs (yaw, then bearing), each normalising then rotating;
// the CORDIC runs are skipped when the target is reached or the arrival latch is set.
// Throughput: one item at a time; the input stalls while an item is in flight or its
// result waits.
// Reset: synchronous, active high; configuration registers, state and out_valid return
// to their defaults and the arrival latch clears. Writes to indices 0-6 also clear it.
`default_nettype none
module go_to_goal_rotate_then_drive (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic signed [15:0] quat_w,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [23:0]             forward_speed,
  output logic signed [24:0]      turn_rate,
  output logic [24:0]             distance_left,
  output logic                    arrived,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  `include "assert_macros.svh"

  // Sequencer codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ = 4'd1;
  localparam logic [3:0] S_SUM = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_QM = 4'd4;
  localparam logic [3:0] S_YAW = 4'd5;
  localparam logic [3:0] S_BRG = 4'd6;
  localparam logic [3:0] S_ERR = 4'd7;
  localparam logic [3:0] S_MUL = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  logic signed [23:0] tgt_x, tgt_y;
  logic [23:0] gain, arrive_dist, lin_lim, ang_lim;
  logic [14:0] head_tol;
  logic reached;

  logic [3:0] state;
  logic signed [24:0] dx, dy;
  logic signed [15:0] qx, qy, qz, qw;
  logic [49:0] dx2, dy2;
  logic [50:0] dsum;
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [35:0] sin_y, cos_y;
  logic [24:0] distance;
  logic signed [17:0] yaw, err;
  logic signed [43:0] rate_prod;
  logic [48:0] fwd_prod;

  logic sq_start, sq_done;
  logic [25:0] sq_root;
  logic cd_start, cd_done;
  logic signed [35:0] cd_y, cd_x;
  logic signed [17:0] cd_ang;
  logic signed [18:0] err_raw;
  logic [17:0] err_mag;
  logic signed [30:0] rate_sh;
  logic [32:0] fwd_sh;

  // The input also stalls while a finished result waits to be taken.
  assign in_stall = (state != S_IDLE) || out_valid;
  // The squared distance is formed from the registered squares, so it is ready
  // in the same cycle that the square root is started.
  assign dsum = 51'(dx2) + 51'(dy2);
  assign sq_start = (state == S_SUM);
  assign cd_start = (state == S_QM && !reached) || (state == S_YAW && cd_done);
  assign cd_y = (state == S_QM) ? sin_y : 36'(dy);
  assign cd_x = (state == S_QM) ? cos_y : 36'(dx);
  assign err_raw = 19'(cd_ang) - 19'(yaw);
  assign err_mag = err[17] ? 18'(-err) : 18'(err);
  assign rate_sh = 31'((rate_prod + 44'sd4096) >>> 13);
  assign fwd_sh = 33'((fwd_prod + 49'd32768) >> 16);

  gtg_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(dsum),
    .done(sq_done), .root(sq_root)
  );

  gtg_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cd_start), .y_in(cd_y), .x_in(cd_x),
    .done(cd_done), .angle(cd_ang)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_x <= '0;
      tgt_y <= '0;
      gain <= 24'd32768;
      arrive_dist <= 24'd3277;
      head_tol <= 15'd82;
      lin_lim <= 24'd13107;
      ang_lim <= 24'd32768;
      reached <= 1'b0;
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gtg_pkg::CfgTargetX: tgt_x <= cfg_data;
          gtg_pkg::CfgTargetY: tgt_y <= cfg_data;
          gtg_pkg::CfgGain: gain <= cfg_data;
          gtg_pkg::CfgArrive: arrive_dist <= cfg_data;
          gtg_pkg::CfgHeading: head_tol <= cfg_data[14:0];
          gtg_pkg::CfgLinear: lin_lim <= cfg_data;
          gtg_pkg::CfgAngular: ang_lim <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= gtg_pkg::CfgAngular) reached <= 1'b0;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            dx <= 25'(tgt_x) - 25'(pos_x);
            dy <= 25'(tgt_y) - 25'(pos_y);
            qx <= quat_x; qy <= quat_y; qz <= quat_z; qw <= quat_w;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          dx2 <= 50'(dx) * 50'(dx);
          dy2 <= 50'(dy) * 50'(dy);
          p_wz <= 32'(qw) * 32'(qz);
          p_xy <= 32'(qx) * 32'(qy);
          p_yy <= 32'(qy) * 32'(qy);
          p_zz <= 32'(qz) * 32'(qz);
          state <= S_SUM;
        end
        S_SUM: begin
          sin_y <= 36'(33'(p_wz) + 33'(p_xy)) <<< 1;
          cos_y <= 36'sd268435456 - (36'(33'(p_yy) + 33'(p_zz)) <<< 1);
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            distance <= sq_root[24:0];
            if (sq_root < 26'(arrive_dist)) reached <= 1'b1;
            state <= S_QM;
          end
        end
        S_QM: state <= reached ? S_OUT : S_YAW;
        S_YAW: if (cd_done) begin
          yaw <= cd_ang;
          state <= S_BRG;
        end
        S_BRG: if (cd_done) begin
          if (err_raw > 19'(gtg_pkg::PiQ13))
            err <= 18'(err_raw - 19'(gtg_pkg::TwoPiQ13));
          else if (err_raw < -19'(gtg_pkg::PiQ13))
            err <= 18'(err_raw + 19'(gtg_pkg::TwoPiQ13));
          else err <= 18'(err_raw);
          state <= S_ERR;
        end
        S_ERR: begin
          rate_prod <= $signed({1'b0, gain}) * err;
          fwd_prod <= gain * distance;
          state <= S_MUL;
        end
        S_MUL: begin
          forward_speed <= '0;
          turn_rate <= '0;
          if (err_mag > 18'(head_tol)) begin
            if (rate_sh > $signed({7'd0, ang_lim})) turn_rate <= $signed({1'b0, ang_lim});
            else if (rate_sh < -$signed({7'd0, ang_lim}))
              turn_rate <= -$signed({1'b0, ang_lim});
            else turn_rate <= 25'(rate_sh);
          end else begin
            forward_speed <= (fwd_sh > 33'(lin_lim)) ? lin_lim : fwd_sh[23:0];
          end
          distance_left <= distance;
          arrived <= 1'b0;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_OUT: begin
          forward_speed <= '0;
          turn_rate <= '0;
          distance_left <= distance;
          arrived <= 1'b1;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_busy_stall, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_IMPLIES(a_arrived_zero, clk, rst, out_valid && arrived,
                  forward_speed == 24'd0 && turn_rate == 25'sd0)
  `ASSERT_IMPLIES(a_one_speed, clk, rst, out_valid,
                  forward_speed == 24'd0 || turn_rate == 25'sd0)
endmodule
`default_nettype wire

### src/gtg_cordic.sv
`default_nettype none
// Iterative CORDIC atan2: normalise one bit position a cycle, then one
// vectoring micro-rotation a cycle. Result is signed Q4.13.
module gtg_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [35:0] y_in,
  input  wire logic signed [35:0] x_in,
  output logic                    done,
  output logic signed [17:0]      angle
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_ROT = 2'd2;

  logic [1:0] state;
  logic signed [37:0] x, y;
  logic signed [gtg_pkg::AngW-1:0] z;
  logic [4:0] step;
  logic signed [37:0] xs, ys;
  logic big;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign big = (x >= 38'sd8589934592) || (x <= -38'sd8589934592)
            || (y >= 38'sd8589934592) || (y <= -38'sd8589934592);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x <= 38'(x_in);
            y <= 38'(y_in);
            z <= '0;
            step <= '0;
            if (x_in == 36'sd0 && y_in == 36'sd0) begin
              angle <= '0;
              done <= 1'b1;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (!big) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            if (x < 0) begin
              if (y >= 0) begin
                x <= y; y <= -x; z <= gtg_pkg::HalfPiQ16;
              end else begin
                x <= -y; y <= x; z <= -gtg_pkg::HalfPiQ16;
              end
            end
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (step == 5'(gtg_pkg::CordicSteps)) begin
            angle <= 18'((z + 40'sd4) >>> 3);
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (y >= 0) begin
              x <= x + ys; y <= y - xs;
              z <= z + 40'(gtg_pkg::atan_entry(step));
            end else begin
              x <= x - ys; y <= y + xs;
              z <= z - 40'(gtg_pkg::atan_entry(step));
            end
            step <= step + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/gtg_isqrt.sv
`default_nettype none
// Bit-serial integer square root, two radicand bits per cycle.
module gtg_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [50:0] value,
  output logic             done,
  output logic [25:0]      root
);
  logic busy;
  logic [5:0] cnt;
  logic [51:0] rad;
  logic [27:0] rem;
  logic [27:0] trial;

  assign trial = {rem[25:0], rad[51:50]} - {root, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        rad <= {1'b0, value};
        rem <= '0;
        root <= '0;
        cnt <= 6'd26;
      end
    end else begin
      rad <= rad << 2;
      if (!trial[27]) begin
        rem <= trial;
        root <= {root[24:0], 1'b1};
      end else begin
        rem <= {rem[25:0], rad[51:50]};
        root <= {root[24:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
